@@ hdl/sclru_pkg.sv @@
// Shared types, constants and helpers for the sector cache LRU lookup unit.
package sclru_pkg;

  localparam int NUM_ENTRIES = 16;
  localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int TAG_W       = 48;
  localparam int TIME_W      = 32;
  localparam int SLOT_W      = 4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [TIME_W-1:0] time_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE
  } state_t;

  // One entry as presented to the compare unit
  typedef struct packed {
    logic  vld;
    logic  first;
    idx_t  idx;
    logic  valid;
    tag_t  tag;
    time_t etime;
  } scan_in_t;

  // Outcome of a full scan
  typedef struct packed {
    logic found;
    idx_t hit_idx;
    idx_t victim_idx;
  } scan_res_t;

  // Give the low slot bits of an entry index
  function automatic logic [SLOT_W-1:0] to_slot(input idx_t idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[SLOT_W-1:0];
  endfunction

endpackage

@@ hdl/sclru_scan_unit.sv @@
// Shared compare unit: tag match and oldest-time search, one entry per beat.
module sclru_scan_unit
  import sclru_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  tag_t      key,
  input  scan_in_t  scan,
  output scan_res_t res
);

  logic  found_r, found_nxt;
  idx_t  hit_idx_r, hit_idx_nxt;
  idx_t  best_idx_r, best_idx_nxt;
  time_t best_time_r, best_time_nxt;
  logic  match;
  time_t eff_time;

  // Invalid entries never match and count as time zero
  assign match    = scan.valid && (scan.tag == key);
  assign eff_time = scan.valid ? scan.etime : '0;

  // Fold one entry into the running hit and victim
  always_comb begin
    found_nxt     = found_r;
    hit_idx_nxt   = hit_idx_r;
    best_idx_nxt  = best_idx_r;
    best_time_nxt = best_time_r;
    if (scan.vld) begin
      if (scan.first) begin
        found_nxt     = match;
        hit_idx_nxt   = scan.idx;
        best_idx_nxt  = scan.idx;
        best_time_nxt = eff_time;
      end else begin
        if (match && !found_r) begin
          found_nxt   = 1'b1;
          hit_idx_nxt = scan.idx;
        end
        if (eff_time < best_time_r) begin
          best_idx_nxt  = scan.idx;
          best_time_nxt = eff_time;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
    hit_idx_r   <= hit_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_time_r <= best_time_nxt;
  end

  assign res.found      = found_r;
  assign res.hit_idx    = hit_idx_r;
  assign res.victim_idx = best_idx_r;

endmodule

@@ hdl/sector_cache_lru_lookup_unit.sv @@
// An accepted access is scanned over all entries (ST_SCAN), drained (ST_DRAIN) and written
// back (ST_WRITE) once the output register is free; a new access is taken only in ST_IDLE.
// The scan reads one tag/time memory entry per cycle through a single shared compare unit.
// A finished result waits in the output register; the next input beat is taken meanwhile.
// Reset (synchronous, active low) clears all valid bits at once; no clearing pass is run.
// Top level of the sector cache LRU lookup unit.
module sector_cache_lru_lookup_unit
  import sclru_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [TAG_W-1:0]  in_sector,
  input  logic [TIME_W-1:0] in_time_stamp,
  input  logic              in_last_sector,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_hit,
  output logic [SLOT_W-1:0] out_slot,
  output logic              out_forward_to_device,
  output logic              out_allocated,
  output logic              out_end_of_request
);

  state_t state_r, state_nxt;
  idx_t   cnt_r, cnt_nxt;

  // Captured access
  logic  kind_r;
  tag_t  sector_r;
  time_t stamp_r;
  logic  last_r;

  // Entry storage
  tag_t  tag_mem  [NUM_ENTRIES];
  time_t time_mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] valid_r;
  logic [NUM_ENTRIES-1:0] dirty_r;

  // Read pipeline
  logic  rd_vld_r;
  idx_t  rd_idx_r;
  tag_t  rd_tag_r;
  time_t rd_time_r;
  logic  rd_valid_r;

  scan_in_t  scan;
  scan_res_t res;

  // Update controls
  logic  fire;
  logic  we_time, we_alloc;
  idx_t  wr_idx;

  // Output register
  logic              out_valid_r;
  logic              out_hit_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_fwd_r;
  logic              out_alloc_r;
  logic              out_eor_r;

  logic in_fire;
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Result may be loaded when the output register is free or being drained
  assign fire = (state_r == ST_WRITE) && (!out_valid_r || out_ready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_fire) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + idx_t'(1);
        if (cnt_r == LAST_IDX) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (fire) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= (state_r == ST_SCAN);
    end
  end

  // Capture the access beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r   <= in_kind;
      sector_r <= in_sector;
      stamp_r  <= in_time_stamp;
      last_r   <= in_last_sector;
    end
  end

  // Registered read of the entry under scan
  always_ff @(posedge clk) begin
    rd_idx_r   <= cnt_r;
    rd_tag_r   <= tag_mem[cnt_r];
    rd_time_r  <= time_mem[cnt_r];
    rd_valid_r <= valid_r[cnt_r];
  end

  assign scan.vld   = rd_vld_r;
  assign scan.first = (rd_idx_r == '0);
  assign scan.idx   = rd_idx_r;
  assign scan.valid = rd_valid_r;
  assign scan.tag   = rd_tag_r;
  assign scan.etime = rd_time_r;

  sclru_scan_unit u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .key   (sector_r),
    .scan  (scan),
    .res   (res)
  );

  // Refresh on a hit, replace the victim on a write miss
  assign we_alloc = fire && !res.found && kind_r;
  assign we_time  = fire && (res.found || kind_r);
  assign wr_idx   = res.found ? res.hit_idx : res.victim_idx;

  always_ff @(posedge clk) begin
    if (we_time) time_mem[wr_idx] <= stamp_r;
    if (we_alloc) tag_mem[wr_idx] <= sector_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
    end else begin
      if (we_alloc) valid_r[wr_idx] <= 1'b1;
      if (we_time && kind_r) dirty_r[wr_idx] <= 1'b1;
    end
  end

  // Output register: load on fire, drop on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_hit_r   <= res.found;
      out_slot_r  <= (res.found || kind_r) ? to_slot(wr_idx) : '0;
      out_fwd_r   <= kind_r || !res.found;
      out_alloc_r <= !res.found && kind_r;
      out_eor_r   <= last_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_hit               = out_hit_r;
  assign out_slot              = out_slot_r;
  assign out_forward_to_device = out_fwd_r;
  assign out_allocated         = out_alloc_r;
  assign out_end_of_request    = out_eor_r;

endmodule

@@ hdl/sclru_checker.sv @@
// Port-level checker for the sector cache LRU lookup unit, with its bind.
module sclru_checker
  import sclru_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_hit,
  input logic [SLOT_W-1:0] out_slot,
  input logic              out_forward_to_device,
  input logic              out_allocated,
  input logic              out_end_of_request
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_slot)
      && $stable(out_forward_to_device) && $stable(out_allocated)
      && $stable(out_end_of_request))
    else $error("stalled result beat changed");

  // A read miss reports slot zero
  a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit && !out_allocated |-> out_slot == '0)
    else $error("read miss with nonzero slot");

  // Allocation only on a miss, and always written through
  a_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_allocated |-> !out_hit && out_forward_to_device)
    else $error("allocation on a hit or without write-through");

  // Only a read hit stays off the device
  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_forward_to_device |-> out_hit)
    else $error("miss not forwarded to the device");

  // The unit is busy right after taking an access
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

endmodule

bind sector_cache_lru_lookup_unit sclru_checker u_sclru_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_valid),
  .in_ready              (in_ready),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_hit               (out_hit),
  .out_slot              (out_slot),
  .out_forward_to_device (out_forward_to_device),
  .out_allocated         (out_allocated),
  .out_end_of_request    (out_end_of_request)
);

@@ sim/sector_cache_lru_lookup_unit_tb.sv @@
// Self-checking testbench for the sector cache LRU lookup unit.
module sector_cache_lru_lookup_unit_tb;
  import sclru_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int POOL_SIZE      = 24;

  typedef enum logic {
    ACC_READ  = 1'b0,
    ACC_WRITE = 1'b1
  } access_kind_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              fwd;
    logic              alloc;
    logic              eor;
  } lookup_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_kind = 1'b0;
  logic [TAG_W-1:0]  in_sector = '0;
  logic [TIME_W-1:0] in_time_stamp = '0;
  logic              in_last_sector = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_hit;
  logic [SLOT_W-1:0] out_slot;
  logic              out_forward_to_device;
  logic              out_allocated;
  logic              out_end_of_request;

  // Shadow copy of the tag store
  logic  cache_valid [NUM_ENTRIES];
  tag_t  cache_tag   [NUM_ENTRIES];
  time_t cache_time  [NUM_ENTRIES];
  logic  cache_dirty [NUM_ENTRIES];

  lookup_result_t lookup_results_due[$];
  tag_t           sector_pool[POOL_SIZE];
  time_t          tick;
  int             mismatches = 0;
  int             results_seen = 0;
  int             quiet_cycles = 0;
  bit             tx_idle_on = 1'b0;
  bit             rx_idle_on = 1'b0;
  logic           hold_req = 1'b0;

  sector_cache_lru_lookup_unit DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_kind               (in_kind),
    .in_sector             (in_sector),
    .in_time_stamp         (in_time_stamp),
    .in_last_sector        (in_last_sector),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_hit               (out_hit),
    .out_slot              (out_slot),
    .out_forward_to_device (out_forward_to_device),
    .out_allocated         (out_allocated),
    .out_end_of_request    (out_end_of_request)
  );

  always #5 clk = ~clk;

  // Look up one access, update the shadow store and give the expected result
  function automatic lookup_result_t predict_lookup(access_kind_t kind, tag_t sector,
                                                    time_t ts, logic last);
    lookup_result_t res;
    int             e;
    int             victim;
    res = '0;
    e = -1;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (e < 0 && cache_valid[i] && cache_tag[i] == sector) e = i;
    end
    if (e >= 0) begin
      res.hit = 1'b1;
      res.slot = e[SLOT_W-1:0];
      cache_time[e] = ts;
      if (kind == ACC_WRITE) cache_dirty[e] = 1'b1;
    end else if (kind == ACC_WRITE) begin
      // Oldest time loses; strict compare keeps the lowest index on a tie
      victim = 0;
      for (int i = 1; i < NUM_ENTRIES; i++) begin
        if (cache_time[i] < cache_time[victim]) victim = i;
      end
      cache_valid[victim] = 1'b1;
      cache_tag[victim]   = sector;
      cache_time[victim]  = ts;
      cache_dirty[victim] = 1'b1;
      res.slot  = victim[SLOT_W-1:0];
      res.alloc = 1'b1;
    end
    res.fwd = (kind == ACC_WRITE) || !res.hit;
    res.eor = last;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  // Offer one access beat and hold it until accepted
  task automatic send_access(access_kind_t kind, tag_t sector, time_t ts, logic last);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_sector      <= sector;
    in_time_stamp  <= ts;
    in_last_sector <= last;
    do @(posedge clk); while (!in_ready);
    lookup_results_due.push_back(predict_lookup(kind, sector, ts, last));
  endtask

  // Drop valid and wait until every lookup has reported
  task automatic drain_lookups();
    in_valid <= 1'b0;
    while (lookup_results_due.size() != 0) @(posedge clk);
  endtask

  function automatic tag_t pick_sector();
    logic [63:0] wide;
    int          r;
    r = $urandom_range(0, 9);
    if (r < 7) return sector_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r == 7) begin
      wide = {$urandom(), $urandom()};
      return wide[TAG_W-1:0];
    end
    return (r == 8) ? '0 : '1;
  endfunction

  // Mostly advancing ticks with ties, occasional jumps and wraps
  function automatic time_t pick_time();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom();
    if (r == 1) tick = 32'hFFFF_FFF0 + $urandom_range(0, 15);
    else tick = tick + $urandom_range(0, 3);
    return tick;
  endfunction

  task automatic send_random_access();
    logic [63:0] wide;
    if ($urandom_range(0, 49) == 0) begin
      wide = {$urandom(), $urandom()};
      sector_pool[$urandom_range(0, POOL_SIZE - 1)] = wide[TAG_W-1:0];
    end
    send_access(access_kind_t'($urandom_range(0, 1)), pick_sector(), pick_time(),
                logic'($urandom_range(0, 1)));
  endtask

  task automatic run_random(int count);
    repeat (count) send_random_access();
  endtask

  // Extremes, ties, wrap and the all-ones tag of invalid entries
  task automatic test_directed_cases();
    send_access(ACC_READ,  48'hFFFF_FFFF_FFFF, 32'd5, 1'b0);
    send_access(ACC_WRITE, 48'hFFFF_FFFF_FFFF, 32'd0, 1'b1);
    send_access(ACC_READ,  48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_access(ACC_WRITE, 48'h0, 32'd0, 1'b0);
    send_access(ACC_WRITE, 48'h1, 32'd0, 1'b1);
    send_access(ACC_READ,  48'h0, 32'd10, 1'b0);
    send_access(ACC_WRITE, 48'h1, 32'd20, 1'b0);
    send_access(ACC_READ,  48'h1, 32'd30, 1'b1);
    send_access(ACC_WRITE, 48'hAAAA_AAAA_AAAA, 32'd40, 1'b0);
    send_access(ACC_WRITE, 48'h5555_5555_5555, 32'd41, 1'b1);
    for (int i = 2; i < 14; i++) send_access(ACC_WRITE, tag_t'(i), time_t'(40 + i), 1'b0);
    send_access(ACC_WRITE, 48'h1234, 32'd100, 1'b0);
    send_access(ACC_READ,  48'hAAAA_AAAA_AAAA, 32'd3, 1'b1);
    send_access(ACC_WRITE, 48'h777, 32'd200, 1'b1);
  endtask

  task automatic test_random_with_idling(int count);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_random(count);
  endtask

  // Stall the result side long enough to fill the block and block input
  task automatic test_output_backpressure();
    tx_idle_on = 1'b0;
    hold_req <= 1'b1;
    run_random(40);
  endtask

  task automatic test_drain_pause();
    tx_idle_on = 1'b1;
    repeat (3) begin
      run_random(10);
      drain_lookups();
    end
  endtask

  task automatic test_no_idling();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random(150);
  endtask

  task automatic check_result();
    lookup_result_t exp;
    if (lookup_results_due.size() == 0) begin
      report_mismatch("result beat with no lookup pending");
    end else begin
      exp = lookup_results_due.pop_front();
      if (out_hit !== exp.hit)
        report_mismatch($sformatf("hit %b, expected %b", out_hit, exp.hit));
      if (out_slot !== exp.slot)
        report_mismatch($sformatf("slot %0d, expected %0d", out_slot, exp.slot));
      if (out_forward_to_device !== exp.fwd)
        report_mismatch($sformatf("forward %b, expected %b", out_forward_to_device, exp.fwd));
      if (out_allocated !== exp.alloc)
        report_mismatch($sformatf("allocated %b, expected %b", out_allocated, exp.alloc));
      if (out_end_of_request !== exp.eor)
        report_mismatch($sformatf("end_of_request %b, expected %b",
                                  out_end_of_request, exp.eor));
    end
    results_seen++;
  endtask

  // Take result beats and stall out_ready in bursts
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_result();
      if (hold_req) begin
        stall_left = LONG_HOLD;
        hold_req <= 1'b0;
      end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Abort when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** sector_cache_lru_lookup_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [63:0] wide;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      cache_valid[i] = 1'b0;
      cache_tag[i]   = '1;
      cache_time[i]  = '0;
      cache_dirty[i] = 1'b0;
    end
    for (int i = 0; i < POOL_SIZE; i++) begin
      wide = {$urandom(), $urandom()};
      sector_pool[i] = wide[TAG_W-1:0];
    end
    tick = $urandom_range(0, 1000);

    // Hold reset, then release at an edge
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_with_idling(700);
    test_output_backpressure();
    test_drain_pause();
    test_random_with_idling(700);
    test_no_idling();

    drain_lookups();
    repeat (NUM_ENTRIES + 4) @(posedge clk);
    if (lookup_results_due.size() != 0) report_mismatch("lookups left without a result");
    if (mismatches == 0) begin
      $display("** sector_cache_lru_lookup_unit: PASSED **");
    end else begin
      $display("** sector_cache_lru_lookup_unit: FAILED **");
    end
    $finish;
  end

endmodule
